// File: rtl/velocity_keybed_scanner_unit_macros.svh
// ----------------------------------------------------------------------------
// Velocity keybed scanner assertion macros
// Shared assertion wrappers for the scanner checker.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_KEYBED_SCANNER_UNIT_MACROS_SVH
`define VELOCITY_KEYBED_SCANNER_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define VKS_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define VKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/vks_pkg.sv
// ----------------------------------------------------------------------------
// Velocity keybed scanner package
// Types and constants shared by the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vks_pkg;

    localparam int KEY_IDX_W = 6;
    localparam int TICK_W    = 32;
    localparam int PHASE_W   = 3;
    localparam int ENTRY_W   = PHASE_W + TICK_W;

    localparam logic [PHASE_W-1:0] PHASE_OFF  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_FULL = 3'd7;
    localparam int                 PHASE_ON_BIT = 2;

    localparam logic [1:0] CONTACT_NONE  = 2'd0;
    localparam logic [1:0] CONTACT_UPPER = 2'd1;
    localparam logic [1:0] CONTACT_BOTH  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } scan_state_t;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic                 key_down;
        logic [TICK_W-1:0]    elapsed_ticks;
    } key_event_t;

endpackage

`default_nettype wire

// File: rtl/velocity_keybed_scanner_unit.sv
// ----------------------------------------------------------------------------
// Velocity keybed scanner unit
// Turns full scans of a two-contact keyboard into key-down and key-up events
// carrying the elapsed scan ticks as a velocity measure.
// ----------------------------------------------------------------------------
// Each beat on the s_ channel is one scan: active-low upper and lower contact
// bits, bit k for key k. Each beat on the m_ channel is one event; the last
// event of a scan carries m_last_event. A scan with no event gives no beat.
// The per-key phase and start time live in one RAM with a registered read;
// the walk reads key k+1 while key k is processed and written back.
// A scan is taken in ST_IDLE, then walks SCAN_KEYS keys at one key per cycle
// while the receiver keeps up; ST_FLUSH then releases its final event, if any.
// Each event is held back in the holding register until the next event of the
// scan is found or the walk ends, so that the last one can be marked; the
// final event moves to the output register in ST_FLUSH once that is free.
// A stalled receiver holds the walk while an event waits in
// the holding register and the output register is full. s_ready is high
// only between scans.
// Reset clears the tick counter, the key valid bits (so every key reads as
// off with a start time of zero) and all handshake state; no RAM sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_keybed_scanner_unit #(
    parameter int SCAN_KEYS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [63:0]                    s_upper_contacts,
    input  wire logic [63:0]                    s_lower_contacts,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [vks_pkg::KEY_IDX_W-1:0]  m_key_index,
    output logic                                m_key_down,
    output logic      [vks_pkg::TICK_W-1:0]     m_elapsed_ticks,
    output logic                                m_last_event
);

    import vks_pkg::*;

    localparam int KW = $clog2(SCAN_KEYS);

    scan_state_t          state_reg, state_next;
    logic [SCAN_KEYS-1:0] up_sh_reg, up_sh_next;
    logic [SCAN_KEYS-1:0] lo_sh_reg, lo_sh_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [SCAN_KEYS-1:0] valid_reg, valid_next;
    logic                 pend_valid_reg, pend_valid_next;
    key_event_t           pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    key_event_t           out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    logic                 ram_we;
    logic [KW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ENTRY_W-1:0]   ram_wdata;

    logic                 out_free;
    logic                 go;
    logic                 last_key;
    logic [PHASE_W-1:0]   phase;
    logic [TICK_W-1:0]    start;
    logic [1:0]           contact;
    logic                 changed;
    logic [PHASE_W-1:0]   phase_new;
    logic [TICK_W-1:0]    start_new;
    logic                 event_hit;
    key_event_t           new_event;

    vks_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SCAN_KEYS)
    ) u_key_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(key_reg),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        go       = (state_reg == ST_WALK) && (!pend_valid_reg || out_free);
        last_key = (key_reg == KW'(SCAN_KEYS - 1));

        phase   = valid_reg[key_reg] ? ram_rdata[TICK_W +: PHASE_W] : PHASE_OFF;
        start   = valid_reg[key_reg] ? ram_rdata[TICK_W-1:0] : '0;
        contact = {~lo_sh_reg[0], ~up_sh_reg[0]};
        changed = (contact != phase[1:0]);

        start_new = start;
        event_hit = 1'b0;
        new_event.key_index     = KEY_IDX_W'(key_reg);
        new_event.elapsed_ticks = tick_reg - start;
        new_event.key_down      = 1'b0;
        case (contact)
            CONTACT_UPPER: begin
                phase_new = {phase[PHASE_ON_BIT], 2'b01};
                start_new = tick_reg;
            end
            CONTACT_BOTH: begin
                phase_new          = PHASE_FULL;
                event_hit          = changed && !phase[PHASE_ON_BIT];
                new_event.key_down = 1'b1;
            end
            default: begin
                phase_new = PHASE_OFF;
                event_hit = changed && phase[PHASE_ON_BIT];
            end
        endcase
        ram_wdata = {phase_new, start_new};
    end

    always_comb begin
        state_next      = state_reg;
        up_sh_next      = up_sh_reg;
        lo_sh_next      = lo_sh_reg;
        tick_next       = tick_reg;
        key_next        = key_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = m_ready ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    up_sh_next = s_upper_contacts[SCAN_KEYS-1:0];
                    lo_sh_next = s_lower_contacts[SCAN_KEYS-1:0];
                    tick_next  = tick_reg + 32'd1;
                    key_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                ram_raddr = key_reg;
                if (go) begin
                    ram_we     = changed;
                    up_sh_next = up_sh_reg >> 1;
                    lo_sh_next = lo_sh_reg >> 1;
                    if (changed) begin
                        valid_next[key_reg] = 1'b1;
                    end
                    if (last_key) begin
                        key_next   = '0;
                        ram_raddr  = '0;
                        state_next = ST_FLUSH;
                    end else begin
                        key_next  = key_reg + KW'(1);
                        ram_raddr = key_reg + KW'(1);
                    end
                    if (event_hit) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_event;
                        pend_valid_next = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        up_sh_reg    <= up_sh_next;
        lo_sh_reg    <= lo_sh_next;
        key_reg      <= key_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = out_valid_reg;
    assign m_key_index     = out_reg.key_index;
    assign m_key_down      = out_reg.key_down;
    assign m_elapsed_ticks = out_reg.elapsed_ticks;
    assign m_last_event    = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/vks_ram.sv
// ----------------------------------------------------------------------------
// Velocity keybed scanner RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vks_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/vks_checker.sv
// ----------------------------------------------------------------------------
// Velocity keybed scanner checker
// Port-level checks on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "velocity_keybed_scanner_unit_macros.svh"

module vks_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [vks_pkg::KEY_IDX_W-1:0] m_key_index,
    input  wire logic                          m_key_down,
    input  wire logic [vks_pkg::TICK_W-1:0]    m_elapsed_ticks,
    input  wire logic                          m_last_event
);

    `VKS_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_key_index) && $stable(m_key_down) && $stable(m_elapsed_ticks) && $stable(m_last_event), "Event beat changed while stalled.")

    `VKS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "Event beat shown straight after reset.")

    `VKS_ASSERT_RST(a_scan_busy, aclk, aresetn, s_valid && s_ready |=> !s_ready ##1 !s_ready, "New scan taken while a key walk runs.")

endmodule

bind velocity_keybed_scanner_unit vks_checker u_vks_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_key_index    (m_key_index),
    .m_key_down     (m_key_down),
    .m_elapsed_ticks(m_elapsed_ticks),
    .m_last_event   (m_last_event)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Velocity keybed scanner testbench
// Sends keyboard scans to the scanner, some hand-picked and many built from
// random key movements, and compares every key event beat with a prediction
// kept by a small scoreboard, under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
    import vks_pkg::*;

    localparam int SCAN_KEYS   = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_SCANS_PER_PHASE = 64;

    typedef struct {
        key_event_t ev;
        logic       last;
    } key_event_exp_t;

    class key_event_board;
        logic [TICK_W-1:0]  tick_now;
        logic [PHASE_W-1:0] phase_of [SCAN_KEYS];
        logic [TICK_W-1:0]  started_at [SCAN_KEYS];
        key_event_exp_t     pending_events [$];
        int                 mismatches;

        function new();
            tick_now   = '0;
            mismatches = 0;
            foreach (phase_of[k]) begin
                phase_of[k]   = PHASE_OFF;
                started_at[k] = '0;
            end
        endfunction

        function void take_scan(logic [63:0] upper, logic [63:0] lower);
            key_event_exp_t     scan_events [$];
            key_event_exp_t     one;
            logic [1:0]         contacts;
            logic [PHASE_W-1:0] ph;
            int                 k;
            tick_now = tick_now + 1'b1;
            for (k = 0; k < SCAN_KEYS; k++) begin
                contacts = {~lower[k], ~upper[k]};
                ph       = phase_of[k];
                if (contacts == ph[1:0]) continue;
                if (contacts == CONTACT_UPPER) begin
                    started_at[k] = tick_now;
                    phase_of[k]   = {ph[PHASE_ON_BIT], CONTACT_UPPER};
                end else if (contacts == CONTACT_BOTH) begin
                    if (!ph[PHASE_ON_BIT]) begin
                        one.ev.key_index     = KEY_IDX_W'(k);
                        one.ev.key_down      = 1'b1;
                        one.ev.elapsed_ticks = tick_now - started_at[k];
                        one.last             = 1'b0;
                        scan_events.push_back(one);
                    end
                    phase_of[k] = PHASE_FULL;
                end else begin
                    if (ph[PHASE_ON_BIT]) begin
                        one.ev.key_index     = KEY_IDX_W'(k);
                        one.ev.key_down      = 1'b0;
                        one.ev.elapsed_ticks = tick_now - started_at[k];
                        one.last             = 1'b0;
                        scan_events.push_back(one);
                    end
                    phase_of[k] = PHASE_OFF;
                end
            end
            if (scan_events.size() > 0) begin
                scan_events[scan_events.size() - 1].last = 1'b1;
            end
            foreach (scan_events[i]) begin
                pending_events.push_back(scan_events[i]);
            end
        endfunction

        function void match_event(logic [KEY_IDX_W-1:0] key_index, logic key_down,
                                  logic [TICK_W-1:0] elapsed_ticks, logic last_event);
            key_event_exp_t want;
            if (pending_events.size() == 0) begin
                $error("key event beat with nothing expected: key_index %0d", key_index);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (key_index !== want.ev.key_index) begin
                $error("key_index: expected %0d, got %0d", want.ev.key_index, key_index);
                mismatches++;
            end
            if (key_down !== want.ev.key_down) begin
                $error("key_down: expected %0d, got %0d", want.ev.key_down, key_down);
                mismatches++;
            end
            if (elapsed_ticks !== want.ev.elapsed_ticks) begin
                $error("elapsed_ticks: expected %0d, got %0d",
                       want.ev.elapsed_ticks, elapsed_ticks);
                mismatches++;
            end
            if (last_event !== want.last) begin
                $error("last_event: expected %0d, got %0d", want.last, last_event);
                mismatches++;
            end
        endfunction

        function int waiting();
            return pending_events.size();
        endfunction
    endclass

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [63:0]          s_upper_contacts = '1;
    logic [63:0]          s_lower_contacts = '1;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [KEY_IDX_W-1:0] m_key_index;
    logic                 m_key_down;
    logic [TICK_W-1:0]    m_elapsed_ticks;
    logic                 m_last_event;

    key_event_board board;
    int             gap_pct      = 0;
    int             stall_pct    = 0;
    int             quiet_cycles = 0;
    int             depth_of [SCAN_KEYS];

    velocity_keybed_scanner_unit #(
        .SCAN_KEYS(SCAN_KEYS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_upper_contacts(s_upper_contacts),
        .s_lower_contacts(s_lower_contacts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_index     (m_key_index),
        .m_key_down      (m_key_down),
        .m_elapsed_ticks (m_elapsed_ticks),
        .m_last_event    (m_last_event)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                board.match_event(m_key_index, m_key_down, m_elapsed_ticks, m_last_event);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL velocity_keybed_scanner_unit");
        $finish;
    end

    task automatic send_scan(input logic [63:0] upper, input logic [63:0] lower);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid          <= 1'b1;
        s_upper_contacts <= upper;
        s_lower_contacts <= lower;
        do @(posedge aclk); while (!s_ready);
        board.take_scan(upper, lower);
    endtask

    // Keys are pressed and released through the upper contact most of the
    // time; a few jump straight across it, and a few show the lower contact
    // closed with the upper one open.
    task automatic random_scan();
        logic [63:0] upper;
        logic [63:0] lower;
        int          k;
        int          roll;
        int          move_pct;
        roll     = $urandom_range(99);
        move_pct = (roll < 70) ? 6 : (roll < 90) ? 25 : 100;
        if ($urandom_range(99) < 8) begin
            upper = {$urandom, $urandom};
            lower = {$urandom, $urandom};
        end else begin
            for (k = 0; k < SCAN_KEYS; k++) begin
                if ($urandom_range(99) < move_pct) begin
                    roll = $urandom_range(99);
                    if (roll < 6) begin
                        depth_of[k] = (depth_of[k] == 0) ? 2 : 0;
                    end else if (depth_of[k] == 1) begin
                        depth_of[k] = (roll < 53) ? 0 : 2;
                    end else begin
                        depth_of[k] = 1;
                    end
                end
                upper[k] = (depth_of[k] == 0);
                lower[k] = (depth_of[k] != 2);
                if ($urandom_range(99) < 2) begin
                    upper[k] = 1'b1;
                    lower[k] = 1'b0;
                end
            end
        end
        send_scan(upper, lower);
    endtask

    initial begin : stimulus
        logic [63:0] ends_mask;
        logic [63:0] key5;
        int          phase;
        int          n;
        board     = new();
        ends_mask = 64'h8000_0000_0000_0001;
        key5      = 64'h0000_0000_0000_0020;
        foreach (depth_of[k]) depth_of[k] = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_scan('1, '1);
        send_scan('0, '0);
        send_scan('0, '0);
        send_scan('0, '1);
        send_scan('1, '1);
        send_scan(~ends_mask, '1);
        send_scan(~ends_mask, ~ends_mask);
        send_scan(~ends_mask, ~64'd1);
        send_scan(~64'd1, ~64'd1);
        send_scan(~64'd1, ~64'd1 & ~key5);
        send_scan(~64'd1, ~64'd1 & ~key5);
        send_scan(~64'd1 & ~key5, ~64'd1 & ~key5);
        send_scan(~64'd1, ~64'd1 & ~key5);
        send_scan(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_scan(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_scan('1, '1);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 54;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 54;
                end
                default: begin
                    gap_pct   = 33;
                    stall_pct = 33;
                end
            endcase
            for (n = 0; n < RANDOM_SCANS_PER_PHASE; n++) begin
                random_scan();
            end
        end
        s_valid <= 1'b0;

        while (board.waiting() > 0) @(posedge aclk);
        repeat (SCAN_KEYS + 40) @(posedge aclk);

        if (board.mismatches == 0 && board.waiting() == 0) begin
            $display("PASS velocity_keybed_scanner_unit");
        end else begin
            $display("FAIL velocity_keybed_scanner_unit");
        end
        $finish;
    end
endmodule
